// File: hw/rtl/hpt_pkg.sv
// shared types, codes and defaults of the pair-table decoder
package hpt_pkg;

  localparam int DEF_MAX_SYMBOLS      = 4096;
  localparam int DEF_MAX_CODE_LENGTHS = 32;
  localparam int DEF_SPARSE_DEPTH     = 4096;
  localparam int DEF_BLOCK_COUNT      = 4096;
  localparam int DEF_DATA_WORDS       = 65536;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [3:0] TS_BASES   = 4'd0;
  localparam logic [3:0] TS_LOWEST  = 4'd1;
  localparam logic [3:0] TS_LEFT    = 4'd2;
  localparam logic [3:0] TS_RIGHT   = 4'd3;
  localparam logic [3:0] TS_COUNTS  = 4'd4;
  localparam logic [3:0] TS_SBLOCK  = 4'd5;
  localparam logic [3:0] TS_SOFFSET = 4'd6;
  localparam logic [3:0] TS_LENGTHS = 4'd7;
  localparam logic [3:0] TS_DATA    = 4'd8;

  localparam logic [1:0] ST_WRITE = 2'd0;
  localparam logic [1:0] ST_OK    = 2'd1;
  localparam logic [1:0] ST_ERR   = 2'd2;

  localparam logic [1:0] CFG_SINGLE = 2'd0;
  localparam logic [1:0] CFG_MINLEN = 2'd1;
  localparam logic [1:0] CFG_SPAN   = 2'd2;
  localparam logic [1:0] CFG_BLOCK  = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  table_sel;
    logic [15:0] address;
    logic [63:0] write_data;
    logic [39:0] position_index;
  } item_t;

  typedef struct packed {
    logic is_lookup;
    logic wr_bad;
  } class_t;

  typedef struct packed {
    logic       single;
    logic [7:0] min_len;
    logic [5:0] span_log2;
    logic [3:0] block_log2;
  } cfg_t;

  typedef struct packed {
    logic [11:0] value;
    logic [1:0]  status;
  } result_t;

  typedef enum logic [4:0] {
    S_IDLE, S_SPARSE, S_BACK, S_BACK_ADD, S_FWD, S_CW1, S_CW2, S_LEN, S_SYM,
    S_CNT, S_REFILL, S_TREE, S_T1, S_T2, S_LEAF, S_RESP
  } back_state_t;

endpackage

// File: hw/rtl/hpt_front.sv
// front end: input queue that classifies each item on entry
module hpt_front import hpt_pkg::*; #(
  parameter int MAX_SYMBOLS      = DEF_MAX_SYMBOLS,
  parameter int MAX_CODE_LENGTHS = DEF_MAX_CODE_LENGTHS,
  parameter int SPARSE_DEPTH     = DEF_SPARSE_DEPTH,
  parameter int BLOCK_COUNT      = DEF_BLOCK_COUNT,
  parameter int DATA_WORDS       = DEF_DATA_WORDS
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  output logic   full,
  input  item_t  item_in,
  input  logic   take,
  output logic   avail,
  output item_t  item_out,
  output class_t cls_out
);

  item_t      items [2];
  class_t     clss [2];
  logic       wptr, rptr;
  logic [1:0] count;
  class_t     cls_in;
  logic [31:0] addr32;
  logic        do_push, do_take;

  assign addr32 = {16'b0, item_in.address};

  always_comb begin
    cls_in.is_lookup = (item_in.cmd == CMD_LOOKUP);
    case (item_in.table_sel)
      TS_BASES, TS_LOWEST: cls_in.wr_bad = (addr32 >= 32'(MAX_CODE_LENGTHS));
      TS_LEFT, TS_RIGHT, TS_COUNTS: cls_in.wr_bad = (addr32 >= 32'(MAX_SYMBOLS));
      TS_SBLOCK, TS_SOFFSET: cls_in.wr_bad = (addr32 >= 32'(SPARSE_DEPTH));
      TS_LENGTHS: cls_in.wr_bad = (addr32 >= 32'(BLOCK_COUNT));
      TS_DATA: cls_in.wr_bad = (addr32 >= 32'(DATA_WORDS));
      default: cls_in.wr_bad = 1'b1;
    endcase
  end

  assign full     = (count == 2'd2);
  assign avail    = (count != 2'd0);
  assign item_out = items[rptr];
  assign cls_out  = clss[rptr];
  assign do_push  = push && !full;
  assign do_take  = take && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      items[wptr] <= item_in;
      clss[wptr]  <= cls_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_take) rptr <= ~rptr;
      count <= count + {1'b0, do_push} - {1'b0, do_take};
    end
  end

endmodule

// File: hw/rtl/hpt_back.sv
// back end: table memories and the lookup sequencer
module hpt_back import hpt_pkg::*; #(
  parameter int MAX_SYMBOLS      = DEF_MAX_SYMBOLS,
  parameter int MAX_CODE_LENGTHS = DEF_MAX_CODE_LENGTHS,
  parameter int SPARSE_DEPTH     = DEF_SPARSE_DEPTH,
  parameter int BLOCK_COUNT      = DEF_BLOCK_COUNT,
  parameter int DATA_WORDS       = DEF_DATA_WORDS
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_valid,
  input  item_t   q_item,
  input  class_t  q_cls,
  output logic    q_take,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  localparam int LW   = (MAX_CODE_LENGTHS > 1) ? $clog2(MAX_CODE_LENGTHS) : 1;
  localparam int LIW  = $clog2(MAX_CODE_LENGTHS + 1);
  localparam int SW   = $clog2(MAX_SYMBOLS);
  localparam int STW  = $clog2(MAX_SYMBOLS + 2);
  localparam int PW   = (SPARSE_DEPTH > 1) ? $clog2(SPARSE_DEPTH) : 1;
  localparam int BW   = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int BIW  = $clog2(BLOCK_COUNT + 1);
  localparam int DW   = $clog2(DATA_WORDS);
  localparam int DIW  = $clog2(DATA_WORDS + 1);

  logic [63:0] mem_lb  [MAX_CODE_LENGTHS];
  logic [11:0] mem_ls  [MAX_CODE_LENGTHS];
  logic [11:0] mem_pl  [MAX_SYMBOLS];
  logic [11:0] mem_pr  [MAX_SYMBOLS];
  logic [7:0]  mem_ec  [MAX_SYMBOLS];
  logic [31:0] mem_sb  [SPARSE_DEPTH];
  logic [15:0] mem_so  [SPARSE_DEPTH];
  logic [15:0] mem_bl  [BLOCK_COUNT];
  logic [31:0] mem_cw  [DATA_WORDS];

  logic [LW-1:0] lb_raddr;
  logic [SW-1:0] pl_raddr, ec_raddr;
  logic [PW-1:0] sp_raddr;
  logic [BW-1:0] bl_raddr;
  logic [DW-1:0] cw_raddr;
  logic [63:0] lb_rd;
  logic [11:0] ls_rd, pl_rd, pr_rd;
  logic [7:0]  ec_rd;
  logic [31:0] sb_rd, cw_rd;
  logic [15:0] so_rd, bl_rd;

  logic wr_en;

  back_state_t       state, state_next;
  logic signed [63:0] off, off_next, posterm, posterm_next;
  logic [BIW-1:0]    blk, blk_next;
  logic [DIW-1:0]    w, w_next;
  logic [63:0]       buff, buff_next;
  logic [6:0]        have, have_next;
  logic [LIW-1:0]    len, len_next;
  logic [63:0]       symraw, symraw_next;
  logic [6:0]        total, total_next;
  logic [11:0]       sym, sym_next, left_r, left_next, right_r, right_next;
  logic [STW-1:0]    steps, steps_next;
  result_t           res_r, res_next;

  logic [39:0] k;
  logic [63:0] span, mask;
  logic [31:0] wv;
  logic [8:0]  tot9;
  logic [63:0] diff;
  logic [8:0]  cnt;
  logic [6:0]  newhave;
  logic [63:0] newbuf;

  assign wr_en = (state == S_IDLE) && q_valid && !q_cls.is_lookup && !q_cls.wr_bad;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (q_item.table_sel)
        TS_BASES:   mem_lb[q_item.address[LW-1:0]] <= q_item.write_data;
        TS_LOWEST:  mem_ls[q_item.address[LW-1:0]] <= q_item.write_data[11:0];
        TS_LEFT:    mem_pl[q_item.address[SW-1:0]] <= q_item.write_data[11:0];
        TS_RIGHT:   mem_pr[q_item.address[SW-1:0]] <= q_item.write_data[11:0];
        TS_COUNTS:  mem_ec[q_item.address[SW-1:0]] <= q_item.write_data[7:0];
        TS_SBLOCK:  mem_sb[q_item.address[PW-1:0]] <= q_item.write_data[31:0];
        TS_SOFFSET: mem_so[q_item.address[PW-1:0]] <= q_item.write_data[15:0];
        TS_LENGTHS: mem_bl[q_item.address[BW-1:0]] <= q_item.write_data[15:0];
        TS_DATA:    mem_cw[q_item.address[DW-1:0]] <= q_item.write_data[31:0];
        default: ;
      endcase
    end
    lb_rd <= mem_lb[lb_raddr];
    ls_rd <= mem_ls[lb_raddr];
    pl_rd <= mem_pl[pl_raddr];
    pr_rd <= mem_pr[pl_raddr];
    ec_rd <= mem_ec[ec_raddr];
    sb_rd <= mem_sb[sp_raddr];
    so_rd <= mem_so[sp_raddr];
    bl_rd <= mem_bl[bl_raddr];
    cw_rd <= mem_cw[cw_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    off     <= off_next;
    posterm <= posterm_next;
    blk     <= blk_next;
    w       <= w_next;
    buff    <= buff_next;
    have    <= have_next;
    len     <= len_next;
    symraw  <= symraw_next;
    total   <= total_next;
    sym     <= sym_next;
    left_r  <= left_next;
    right_r <= right_next;
    steps   <= steps_next;
    res_r   <= res_next;
  end

  assign res_valid = (state == S_RESP);
  assign res       = res_r;

  always_comb begin
    state_next   = state;
    off_next     = off;
    posterm_next = posterm;
    blk_next     = blk;
    w_next       = w;
    buff_next    = buff;
    have_next    = have;
    len_next     = len;
    symraw_next  = symraw;
    total_next   = total;
    sym_next     = sym;
    left_next    = left_r;
    right_next   = right_r;
    steps_next   = steps;
    res_next     = res_r;
    q_take       = 1'b0;
    lb_raddr     = '0;
    pl_raddr     = sym[SW-1:0];
    ec_raddr     = sym[SW-1:0];
    sp_raddr     = '0;
    bl_raddr     = blk[BW-1:0];
    cw_raddr     = w[DW-1:0];
    k       = q_item.position_index >> cfg.span_log2;
    span    = 64'd1 << cfg.span_log2;
    mask    = span - 64'd1;
    wv      = ({{(32-BW){1'b0}}, blk[BW-1:0]} << cfg.block_log2) >> 2;
    tot9    = 9'(len) + {1'b0, cfg.min_len};
    diff    = buff - lb_rd;
    cnt     = {1'b0, ec_rd} + 9'd1;
    newhave = have - total;
    newbuf  = (total >= 7'd64) ? 64'd0 : (buff << total[5:0]);

    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_take = 1'b1;
          res_next.value = 12'd0;
          if (!q_cls.is_lookup) begin
            res_next.status = q_cls.wr_bad ? ST_ERR : ST_WRITE;
            state_next = S_RESP;
          end else if (cfg.single) begin
            res_next.value  = {4'b0, cfg.min_len};
            res_next.status = ST_OK;
            state_next = S_RESP;
          end else if ({24'b0, k} >= 64'(SPARSE_DEPTH)) begin
            res_next.status = ST_ERR;
            state_next = S_RESP;
          end else begin
            sp_raddr = k[PW-1:0];
            posterm_next = $signed({24'b0, q_item.position_index} & mask)
                           - $signed(span >> 1);
            state_next = S_SPARSE;
          end
        end
      end
      S_SPARSE: begin
        if (sb_rd >= 32'(BLOCK_COUNT)) begin
          res_next.status = ST_ERR;
          state_next = S_RESP;
        end else begin
          blk_next = sb_rd[BIW-1:0];
          off_next = $signed({48'b0, so_rd}) + posterm;
          state_next = S_BACK;
        end
      end
      S_BACK: begin
        if (off < 0) begin
          if (blk == '0) begin
            res_next.status = ST_ERR;
            state_next = S_RESP;
          end else begin
            blk_next = blk - 1'b1;
            bl_raddr = blk_next[BW-1:0];
            state_next = S_BACK_ADD;
          end
        end else begin
          state_next = S_FWD;
        end
      end
      S_BACK_ADD: begin
        off_next = off + $signed({48'b0, bl_rd}) + 64'sd1;
        state_next = S_BACK;
      end
      S_FWD: begin
        if (off > $signed({48'b0, bl_rd})) begin
          off_next = off - $signed({48'b0, bl_rd}) - 64'sd1;
          if (32'(blk) + 32'd1 >= 32'(BLOCK_COUNT)) begin
            res_next.status = ST_ERR;
            state_next = S_RESP;
          end else begin
            blk_next = blk + 1'b1;
            bl_raddr = blk_next[BW-1:0];
          end
        end else if (wv + 32'd1 >= 32'(DATA_WORDS)) begin
          res_next.status = ST_ERR;
          state_next = S_RESP;
        end else begin
          w_next = wv[DIW-1:0];
          cw_raddr = wv[DW-1:0];
          state_next = S_CW1;
        end
      end
      S_CW1: begin
        buff_next = {cw_rd, 32'b0};
        cw_raddr = DW'(w + 1'b1);
        state_next = S_CW2;
      end
      S_CW2: begin
        buff_next = {buff[63:32], cw_rd};
        w_next = w + DIW'(2);
        have_next = 7'd64;
        len_next = '0;
        lb_raddr = '0;
        state_next = S_LEN;
      end
      S_LEN: begin
        if (buff < lb_rd) begin
          if (32'(len) + 32'd1 >= 32'(MAX_CODE_LENGTHS)) begin
            res_next.status = ST_ERR;
            state_next = S_RESP;
          end else begin
            len_next = len + 1'b1;
            lb_raddr = len_next[LW-1:0];
          end
        end else if (tot9 == 9'd0 || tot9 > 9'd64 || tot9 > {2'b0, have}) begin
          res_next.status = ST_ERR;
          state_next = S_RESP;
        end else begin
          total_next  = tot9[6:0];
          symraw_next = (diff >> (7'd64 - tot9[6:0])) + {52'b0, ls_rd};
          state_next = S_SYM;
        end
      end
      S_SYM: begin
        if (symraw >= 64'(MAX_SYMBOLS)) begin
          res_next.status = ST_ERR;
          state_next = S_RESP;
        end else begin
          sym_next = symraw[11:0];
          ec_raddr = symraw[SW-1:0];
          state_next = S_CNT;
        end
      end
      S_CNT: begin
        if (off < $signed({55'b0, cnt})) begin
          steps_next = '0;
          state_next = S_TREE;
        end else begin
          off_next  = off - $signed({55'b0, cnt});
          buff_next = newbuf;
          have_next = newhave;
          if (newhave <= 7'd32) begin
            if (32'(w) >= 32'(DATA_WORDS)) begin
              res_next.status = ST_ERR;
              state_next = S_RESP;
            end else begin
              state_next = S_REFILL;
            end
          end else begin
            len_next = '0;
            state_next = S_LEN;
          end
        end
      end
      S_REFILL: begin
        have_next = have + 7'd32;
        buff_next = buff | ({32'b0, cw_rd} << (7'd32 - have));
        w_next = w + 1'b1;
        len_next = '0;
        state_next = S_LEN;
      end
      S_TREE: begin
        state_next = (ec_rd == 8'd0) ? S_LEAF : S_T1;
      end
      S_T1: begin
        right_next = pr_rd;
        left_next  = pl_rd;
        if (32'(steps) + 32'd1 > 32'(MAX_SYMBOLS) ||
            {20'b0, pl_rd} >= 32'(MAX_SYMBOLS)) begin
          res_next.status = ST_ERR;
          state_next = S_RESP;
        end else begin
          steps_next = steps + 1'b1;
          ec_raddr = pl_rd[SW-1:0];
          state_next = S_T2;
        end
      end
      S_T2: begin
        if (off < $signed({55'b0, cnt})) begin
          sym_next = left_r;
          ec_raddr = left_r[SW-1:0];
          state_next = S_TREE;
        end else begin
          off_next = off - $signed({55'b0, cnt});
          if ({20'b0, right_r} >= 32'(MAX_SYMBOLS)) begin
            res_next.status = ST_ERR;
            state_next = S_RESP;
          end else begin
            sym_next = right_r;
            ec_raddr = right_r[SW-1:0];
            state_next = S_TREE;
          end
        end
      end
      S_LEAF: begin
        res_next.value  = pl_rd;
        res_next.status = ST_OK;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/hpt_outq.sv
// two-entry result queue toward the receiver
module hpt_outq import hpt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_res,
  output logic    empty,
  input  logic    pop,
  output result_t out_res
);

  result_t    slots [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign in_ready = (count != 2'd2);
  assign empty    = (count == 2'd0);
  assign out_res  = slots[rptr];
  assign do_push  = in_valid && in_ready;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) slots[wptr] <= in_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop) rptr <= ~rptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// File: hw/rtl/huffman_pair_table_decoder_core.sv
// top level of the pair-table decoder: config registers, front, back, result queue
//
// items enter through push/full: a write loads one table entry, a lookup
// decodes one position. results leave through empty/pop with value and status,
// oldest first, one result per item.
// a write or a single-value lookup goes from accept straight to the result state.
// a lookup walks blocks forward or backward through the block lengths,
// then decodes symbols, probing the length table once per code length,
// then descends the pair tree one level at a time. the single read port
// of each table memory sets the pace of the walk.
// the front queue holds two items and the result queue two results, so input
// keeps flowing while a result waits; a stalled receiver stops the sequencer
// once the result queue is full.
// config writes through cfg_valid/cfg_ready are always taken and must only
// happen while the block is idle.
// reset empties both queues and loads the register defaults; table memories
// are undefined until written.
module huffman_pair_table_decoder_core import hpt_pkg::*; #(
  parameter int MAX_SYMBOLS      = DEF_MAX_SYMBOLS,
  parameter int MAX_CODE_LENGTHS = DEF_MAX_CODE_LENGTHS,
  parameter int SPARSE_DEPTH     = DEF_SPARSE_DEPTH,
  parameter int BLOCK_COUNT      = DEF_BLOCK_COUNT,
  parameter int DATA_WORDS       = DEF_DATA_WORDS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        cmd,
  input  logic [3:0]  table_sel,
  input  logic [15:0] address,
  input  logic [63:0] write_data,
  input  logic [39:0] position_index,
  output logic        empty,
  input  logic        pop,
  output logic [11:0] value,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  cfg_t    cfg;
  item_t   item_in, q_item;
  class_t  q_cls;
  logic    q_valid, q_take;
  logic    res_valid, res_ready;
  result_t res, out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.single     <= 1'b0;
      cfg.min_len    <= 8'd1;
      cfg.span_log2  <= 6'd10;
      cfg.block_log2 <= 4'd6;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SINGLE: cfg.single     <= cfg_data[0];
        CFG_MINLEN: cfg.min_len    <= cfg_data;
        CFG_SPAN:   cfg.span_log2  <= cfg_data[5:0];
        CFG_BLOCK:  cfg.block_log2 <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign item_in.cmd            = cmd;
  assign item_in.table_sel      = table_sel;
  assign item_in.address        = address;
  assign item_in.write_data     = write_data;
  assign item_in.position_index = position_index;

  hpt_front #(
    .MAX_SYMBOLS(MAX_SYMBOLS), .MAX_CODE_LENGTHS(MAX_CODE_LENGTHS),
    .SPARSE_DEPTH(SPARSE_DEPTH), .BLOCK_COUNT(BLOCK_COUNT), .DATA_WORDS(DATA_WORDS)
  ) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .item_in(item_in),
    .take(q_take), .avail(q_valid), .item_out(q_item), .cls_out(q_cls)
  );

  hpt_back #(
    .MAX_SYMBOLS(MAX_SYMBOLS), .MAX_CODE_LENGTHS(MAX_CODE_LENGTHS),
    .SPARSE_DEPTH(SPARSE_DEPTH), .BLOCK_COUNT(BLOCK_COUNT), .DATA_WORDS(DATA_WORDS)
  ) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_valid(q_valid), .q_item(q_item),
    .q_cls(q_cls), .q_take(q_take), .res_valid(res_valid), .res_ready(res_ready),
    .res(res)
  );

  hpt_outq u_outq (
    .clk(clk), .rst(rst), .in_valid(res_valid), .in_ready(res_ready), .in_res(res),
    .empty(empty), .pop(pop), .out_res(out_res)
  );

  assign value  = out_res.value;
  assign status = out_res.status;

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_OK) |-> value == 12'd0)
    else $error("nonzero value on write or error result");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (status == ST_WRITE || status == ST_OK || status == ST_ERR))
    else $error("undefined status code");

  a_take_room: assert property (@(posedge clk) disable iff (rst)
    (q_take && q_valid) |=> !full)
    else $error("front queue full after a take");

endmodule

// File: verif/huffman_pair_table_decoder_core_tb.sv
// testbench for the pair-table decoder core: table loads, lookups, errors, register settings
module huffman_pair_table_decoder_core_tb;
  import hpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSYM = DEF_MAX_SYMBOLS;
  localparam int NLEN = DEF_MAX_CODE_LENGTHS;
  localparam int NSPARSE = DEF_SPARSE_DEPTH;
  localparam int NBLK = DEF_BLOCK_COUNT;
  localparam int NWORDS = DEF_DATA_WORDS;
  localparam int IDLE_LIMIT = 200000;
  localparam int NSYM_USED = 24;
  localparam int NBLK_USED = 8;
  localparam int NWORDS_USED = (NBLK_USED + 2) * 16;

  logic clk = 1'b0, rst = 1'b1;
  logic push = 1'b0, pop = 1'b0, full, empty;
  logic cmd = CMD_WRITE;
  logic [3:0] table_sel = TS_BASES;
  logic [15:0] address = '0;
  logic [63:0] write_data = '0;
  logic [39:0] position_index = '0;
  logic [11:0] value;
  logic [1:0] status;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [1:0] cfg_index = CFG_SINGLE;
  logic [7:0] cfg_data = '0;

  huffman_pair_table_decoder_core dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // decoder copy: registers and tables with written flags
  logic reg_single;
  logic [7:0] reg_min_len;
  logic [5:0] reg_span;
  logic [3:0] reg_block;
  logic [63:0] bases_m [NLEN];
  logic [11:0] lowest_m [NLEN];
  logic [11:0] left_m [NSYM];
  logic [11:0] right_m [NSYM];
  logic [7:0] counts_m [NSYM];
  logic [31:0] sblock_m [NSPARSE];
  logic [15:0] soffset_m [NSPARSE];
  logic [15:0] blen_m [NBLK];
  logic [31:0] words_m [NWORDS];
  bit bases_w [NLEN], lowest_w [NLEN], left_w [NSYM], right_w [NSYM], counts_w [NSYM];
  bit sblock_w [NSPARSE], soffset_w [NSPARSE], blen_w [NBLK], words_w [NWORDS];

  result_t pending_results[$];
  int errors = 0, n_writes = 0, n_ok = 0, n_err = 0, n_checked = 0;
  bit quiet = 0;
  bit stim_done = 0;

  function automatic int gap();
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  // returns 0 when the lookup would read a table entry never loaded
  function automatic bit decode_position(input logic [39:0] pos, output result_t r);
    longint unsigned k, blk, span, w, buf_bits, sym, len, total, cnt, lft, steps;
    longint off, have;
    r.value = '0;
    r.status = ST_ERR;
    if (reg_single) begin
      r.value = {4'd0, reg_min_len};
      r.status = ST_OK;
      return 1;
    end
    k = longint'(pos) >> reg_span;
    if (k >= NSPARSE) return 1;
    if (!sblock_w[k] || !soffset_w[k]) return 0;
    blk = sblock_m[k];
    if (blk >= NBLK) return 1;
    span = 64'd1 << reg_span;
    off = longint'(soffset_m[k]) + longint'(pos & (span - 1)) - longint'(span >> 1);
    while (off < 0) begin
      if (blk == 0) return 1;
      blk--;
      if (!blen_w[blk]) return 0;
      off += longint'(blen_m[blk]) + 1;
    end
    forever begin
      if (!blen_w[blk]) return 0;
      if (off <= longint'(blen_m[blk])) break;
      off -= longint'(blen_m[blk]) + 1;
      blk++;
      if (blk >= NBLK) return 1;
    end
    w = (blk << reg_block) >> 2;
    if (w + 1 >= NWORDS) return 1;
    if (!words_w[w] || !words_w[w + 1]) return 0;
    buf_bits = {words_m[w], words_m[w + 1]};
    w += 2;
    have = 64;
    forever begin
      len = 0;
      forever begin
        if (len >= NLEN) break;
        if (!bases_w[len]) return 0;
        if (buf_bits >= bases_m[len]) break;
        len++;
      end
      if (len >= NLEN) return 1;
      total = len + reg_min_len;
      if (total == 0 || total > 64 || longint'(total) > have) return 1;
      if (!lowest_w[len]) return 0;
      sym = ((buf_bits - bases_m[len]) >> (64 - total)) + lowest_m[len];
      if (sym >= NSYM) return 1;
      if (!counts_w[sym]) return 0;
      cnt = counts_m[sym] + 1;
      if (off < longint'(cnt)) break;
      off -= longint'(cnt);
      buf_bits = (total >= 64) ? 64'd0 : (buf_bits << total);
      have -= longint'(total);
      if (have <= 32) begin
        if (w >= NWORDS) return 1;
        if (!words_w[w]) return 0;
        have += 32;
        buf_bits |= longint'(words_m[w]) << (64 - have);
        w++;
      end
    end
    steps = 0;
    while (counts_m[sym] != 0) begin
      if (!left_w[sym]) return 0;
      lft = left_m[sym];
      steps++;
      if (steps > NSYM || lft >= NSYM) return 1;
      if (!counts_w[lft]) return 0;
      if (off < longint'(counts_m[lft]) + 1) begin
        sym = lft;
      end else begin
        off -= longint'(counts_m[lft]) + 1;
        if (!right_w[sym]) return 0;
        sym = right_m[sym];
        if (sym >= NSYM) return 1;
      end
      if (!counts_w[sym]) return 0;
    end
    if (!left_w[sym]) return 0;
    r.value = left_m[sym];
    r.status = ST_OK;
    return 1;
  endfunction

  function automatic logic [1:0] load_entry(input logic [3:0] sel, input logic [15:0] a,
                                            input logic [63:0] d);
    case (sel)
      TS_BASES: begin
        if (a >= NLEN) return ST_ERR;
        bases_m[a] = d; bases_w[a] = 1;
      end
      TS_LOWEST: begin
        if (a >= NLEN) return ST_ERR;
        lowest_m[a] = d[11:0]; lowest_w[a] = 1;
      end
      TS_LEFT: begin
        if (a >= NSYM) return ST_ERR;
        left_m[a] = d[11:0]; left_w[a] = 1;
      end
      TS_RIGHT: begin
        if (a >= NSYM) return ST_ERR;
        right_m[a] = d[11:0]; right_w[a] = 1;
      end
      TS_COUNTS: begin
        if (a >= NSYM) return ST_ERR;
        counts_m[a] = d[7:0]; counts_w[a] = 1;
      end
      TS_SBLOCK: begin
        if (a >= NSPARSE) return ST_ERR;
        sblock_m[a] = d[31:0]; sblock_w[a] = 1;
      end
      TS_SOFFSET: begin
        if (a >= NSPARSE) return ST_ERR;
        soffset_m[a] = d[15:0]; soffset_w[a] = 1;
      end
      TS_LENGTHS: begin
        if (a >= NBLK) return ST_ERR;
        blen_m[a] = d[15:0]; blen_w[a] = 1;
      end
      TS_DATA: begin
        if (a >= NWORDS) return ST_ERR;
        words_m[a] = d[31:0]; words_w[a] = 1;
      end
      default: return ST_ERR;
    endcase
    return ST_WRITE;
  endfunction

  task automatic report(input string what, input logic [11:0] got, input logic [11:0] want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // one item transfer; expectation queued at acceptance
  task automatic send_item(input logic c, input logic [3:0] sel, input logic [15:0] a,
                           input logic [63:0] d, input logic [39:0] pos);
    int g;
    result_t r;
    g = gap();
    @(negedge clk);
    if (g > 0) begin
      push = 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    cmd = c; table_sel = sel; address = a; write_data = d; position_index = pos;
    push = 1'b1;
    do @(posedge clk); while (full);
    if (c == CMD_WRITE) begin
      r.value = '0;
      r.status = load_entry(sel, a, d);
      n_writes++;
    end else begin
      void'(decode_position(pos, r));
      if (r.status == ST_OK) n_ok++; else n_err++;
    end
    pending_results.push_back(r);
  endtask

  task automatic write_table(input logic [3:0] sel, input int a, input logic [63:0] d);
    send_item(CMD_WRITE, sel, a[15:0], d, 40'($urandom));
  endtask

  task automatic look_up(input logic [39:0] pos);
    send_item(CMD_LOOKUP, 4'($urandom), 16'($urandom), {$urandom, $urandom}, pos);
  endtask

  task automatic drain();
    @(negedge clk);
    push = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [7:0] d);
    drain();
    @(negedge clk);
    cfg_index = idx; cfg_data = d; cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SINGLE: reg_single = d[0];
      CFG_MINLEN: reg_min_len = d;
      CFG_SPAN: reg_span = d[5:0];
      default: reg_block = d[3:0];
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // result side
  initial begin
    result_t want;
    int g;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      g = gap();
      if (g > 0) begin
        pop = 1'b0;
        repeat (g) @(negedge clk);
      end
      pop = 1'b1;
      do @(posedge clk); while (empty);
      if (pending_results.size() == 0) begin
        errors++;
        $display("result with nothing expected at %0t", $realtime);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (value !== want.value) report("value", value, want.value);
        if (status !== want.status) report("status", status, want.status);
      end
      @(negedge clk);
    end
  end

  // watchdog on cycles without any transfer
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_load_tables();
    // length 4 codes for high buffers, length 5 below; symbols 16..23 are pairs
    // the second length base is zero, so the length scan never goes further
    set_reg(CFG_MINLEN, 8'd4);
    set_reg(CFG_SPAN, 8'd4);
    for (int i = 0; i < 2; i++) begin
      write_table(TS_BASES, i, (i == 0) ? 64'h8000_0000_0000_0000 : 64'd0);
      write_table(TS_LOWEST, i, (i == 1) ? 64'd8 : 64'd0);
    end
    for (int s = 0; s < NSYM_USED; s++) begin
      write_table(TS_COUNTS, s, (s >= 16 && s < 24) ? 64'd1 : 64'd0);
      write_table(TS_LEFT, s, (s >= 16 && s < 24) ? 64'(s - 16) : {$urandom, $urandom});
      write_table(TS_RIGHT, s, (s >= 16 && s < 24) ? 64'(s - 8) : {$urandom, $urandom});
    end
    for (int b = 0; b <= NBLK_USED; b++) begin
      write_table(TS_LENGTHS, b, 64'($urandom_range(4, 15)));
      if (b < NBLK_USED) begin
        write_table(TS_SBLOCK, b, 64'(b));
        write_table(TS_SOFFSET, b, 64'd8);
      end
    end
    for (int w = 0; w < NWORDS_USED; w++) write_table(TS_DATA, w, {$urandom, $urandom});
  endtask

  task automatic test_directed();
    look_up(40'd0);
    look_up(40'd20);
    look_up(40'hFF_FFFF_FFFF);
    write_table(4'd9, 0, '1);
    write_table(4'd15, 16'hFFFF, '1);
    write_table(TS_BASES, 32, '1);
    write_table(TS_LOWEST, 16'hFFFF, '1);
    write_table(TS_LEFT, NSYM, '1);
    write_table(TS_SBLOCK, NSPARSE, '1);
    write_table(TS_LENGTHS, 16'hFFFF, '1);
    write_table(TS_DATA, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    // block index past the table, then a block whose data lies beyond memory
    write_table(TS_SBLOCK, NBLK_USED - 1, 64'(NBLK));
    look_up(40'(NBLK_USED - 1) << 4);
    write_table(TS_LENGTHS, NBLK - 1, 64'hFFFF);
    write_table(TS_SBLOCK, NBLK_USED - 1, 64'(NBLK - 1));
    set_reg(CFG_BLOCK, 8'd10);
    look_up((40'(NBLK_USED - 1) << 4) + 40'd9);
    set_reg(CFG_BLOCK, 8'd6);
    write_table(TS_SBLOCK, NBLK_USED - 1, 64'(NBLK_USED - 1));
    // symbol out of range; the top symbol itself is a plain leaf
    write_table(TS_COUNTS, NSYM - 1, 64'd0);
    write_table(TS_LEFT, NSYM - 1, 64'd0);
    write_table(TS_LOWEST, 0, 64'hFFF);
    look_up(40'd3 << 4);
    write_table(TS_LOWEST, 0, 64'd0);
    // pair that points at itself
    write_table(TS_LEFT, 16, 64'd16);
    write_table(TS_LOWEST, 0, 64'd16);
    look_up(40'd5 << 4);
    write_table(TS_LOWEST, 0, 64'd0);
    write_table(TS_LEFT, 16, 64'd0);
  endtask

  task automatic test_random(input int n);
    result_t r;
    logic [39:0] pos;
    bit found;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 25) begin
        case ($urandom_range(0, 6))
          0: write_table(TS_DATA, $urandom_range(0, NWORDS_USED - 1), {$urandom, $urandom});
          1: write_table(TS_LEFT, $urandom_range(0, NSYM_USED - 1), {$urandom, $urandom});
          2: write_table(TS_LENGTHS, $urandom_range(0, NBLK_USED),
                         64'($urandom_range(0, 20)));
          3: write_table(TS_SOFFSET, $urandom_range(0, NBLK_USED - 1),
                         64'($urandom_range(0, 40)));
          4: write_table(TS_COUNTS, $urandom_range(0, 15), 64'd0);
          5: write_table(TS_SBLOCK, $urandom_range(0, NBLK_USED - 1),
                         64'($urandom_range(0, NBLK_USED)));
          default: send_item(CMD_WRITE, 4'($urandom), 16'($urandom), {$urandom, $urandom},
                             40'({$urandom, $urandom}));
        endcase
      end else begin
        found = 0;
        for (int t = 0; t < 30 && !found; t++) begin
          if ($urandom_range(0, 19) == 0)
            pos = 40'({$urandom, $urandom});
          else
            pos = (40'($urandom_range(0, NBLK_USED - 1)) << reg_span) |
                  (40'({$urandom, $urandom}) & ((40'd1 << reg_span) - 40'd1));
          found = decode_position(pos, r);
        end
        if (found) look_up(pos);
        else write_table(TS_DATA, $urandom_range(0, NWORDS_USED - 1), {$urandom, $urandom});
      end
    end
  endtask

  task automatic test_settings();
    set_reg(CFG_SINGLE, 8'd1);
    set_reg(CFG_MINLEN, 8'd0);
    look_up(40'd0);
    look_up(40'hFF_FFFF_FFFF);
    set_reg(CFG_MINLEN, 8'd255);
    test_random(10);
    set_reg(CFG_SINGLE, 8'd0);
    test_random(10);
    set_reg(CFG_MINLEN, 8'd0);
    test_random(10);
    set_reg(CFG_MINLEN, 8'd4);
    set_reg(CFG_SPAN, 8'd1);
    test_random(20);
    set_reg(CFG_SPAN, 8'd40);
    test_random(10);
    set_reg(CFG_SPAN, 8'd3);
    set_reg(CFG_BLOCK, 8'd5);
    test_random(20);
    set_reg(CFG_BLOCK, 8'd10);
    test_random(10);
    set_reg(CFG_BLOCK, 8'd6);
    set_reg(CFG_SPAN, 8'd4);
  endtask

  initial begin
    reg_single = 0; reg_min_len = 8'd1; reg_span = 6'd10; reg_block = 4'd6;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_load_tables();
    test_directed();
    test_settings();
    test_random(100);
    quiet = 1;
    test_random(30);
    quiet = 0;
    test_random(40);
    drain();
    $display("checked %0d results: %0d table writes, %0d good lookups, %0d error answers",
             n_checked, n_writes, n_ok, n_err);
    $display("register settings covered single value, code length and span/block extremes");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/hpt_pkg.sv
hw/rtl/hpt_front.sv
hw/rtl/hpt_back.sv
hw/rtl/hpt_outq.sv
hw/rtl/huffman_pair_table_decoder_core.sv
verif/huffman_pair_table_decoder_core_tb.sv
